[rtl/flt_pkg.sv]
// shared types and constants for the frame timeline lookup block
// command and status structs between controller and datapath, field widths, codes
// no dependencies
package flt_pkg;

	localparam int AMT_W     = 40;
	localparam int TOT_W     = 48;
	localparam int IDX_OUT_W = 8;
	localparam int CNT_OUT_W = 9;
	localparam int BIT_W     = 6;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic REG_LOOP_ENABLE = 1'b0;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEL_ZERO = 2'd0,
		SEL_LAST = 2'd1,
		SEL_WALK = 2'd2
	} idx_sel_t;

	typedef struct packed {
		logic     load;
		logic     append;
		logic     emit;
		idx_sel_t emit_sel;
		status_t  emit_status;
		logic     mod_start;
		logic     mod_step;
		logic     load_time;
		logic     walk_start;
		logic     walk_step;
	} dp_cmd_t;

	typedef struct packed {
		logic is_append;
		logic full;
		logic empty;
		logic total_zero;
		logic amt_ge_total;
		logic mod_last;
		logic walk_end;
	} dp_stat_t;

endpackage

[rtl/flt_dp.sv]
// datapath: delay memory, frame count and saturating total, bit-serial modulo,
// cumulative walk and result registers; driven by flt_ctrl commands
// depends on flt_pkg
module flt_dp #(
	parameter int MAX_FRAMES = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  flt_pkg::dp_cmd_t                 cmd,
	output flt_pkg::dp_stat_t                stat,
	input  logic                             operation,
	input  logic [flt_pkg::AMT_W-1:0]        amount_ms,
	output logic                             done,
	output logic [flt_pkg::IDX_OUT_W-1:0]    frame_index,
	output logic [1:0]                       status,
	output logic [flt_pkg::CNT_OUT_W-1:0]    frame_count,
	output logic [flt_pkg::TOT_W-1:0]        total_ms
);
	import flt_pkg::*;

	localparam int IDX_W = $clog2(MAX_FRAMES);
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int ACC_W = AMT_W + $clog2(MAX_FRAMES);
	localparam int CMP_W = (ACC_W > TOT_W) ? ACC_W : TOT_W;

	logic [AMT_W-1:0] mem [MAX_FRAMES];

	logic             op_q;
	logic [AMT_W-1:0] amount_q;
	logic [CNT_W-1:0] count_q;
	logic [TOT_W-1:0] total_q;
	logic [TOT_W-1:0] rem_q;
	logic [BIT_W-1:0] bit_q;
	logic [IDX_W-1:0] rd_addr_q;
	logic [AMT_W-1:0] rdata_q;
	logic             rd_v_q;
	logic [IDX_W-1:0] data_idx_q;
	logic [ACC_W-1:0] acc_q;
	logic             done_q;
	logic [IDX_OUT_W-1:0] frame_index_q;
	logic [1:0]           status_q;
	logic [CNT_OUT_W-1:0] frame_count_q;
	logic [TOT_W-1:0]     total_ms_q;

	logic             full;
	logic [TOT_W:0]   tot_sum;
	logic [TOT_W-1:0] total_d;
	logic [TOT_W:0]   rem_sh;
	logic [TOT_W:0]   rem_nxt;
	logic [ACC_W-1:0] acc_sum;
	logic             hit;
	logic             last;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] cnt_p1;
	logic [IDX_W-1:0] idx_pick;
	logic [IDX_W+IDX_OUT_W-1:0] idx_ext;
	logic [CNT_W-1:0] cnt_pick;
	logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
	status_t          sts_pick;

	assign full    = (count_q == CNT_W'(MAX_FRAMES));
	assign tot_sum = {1'b0, total_q} + (TOT_W+1)'(amount_q);
	assign total_d = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];

	// restoring remainder step, one dividend bit per cycle, msb first
	assign rem_sh  = {rem_q, amount_q[bit_q]};
	assign rem_nxt = (rem_sh >= {1'b0, total_q}) ? rem_sh - {1'b0, total_q} : rem_sh;

	assign acc_sum = acc_q + ACC_W'(rdata_q);
	assign hit     = CMP_W'(rem_q) < CMP_W'(acc_sum);
	assign cnt_m1  = count_q - CNT_W'(1);
	assign cnt_p1  = count_q + CNT_W'(1);
	assign last    = (data_idx_q == cnt_m1[IDX_W-1:0]);

	always_comb begin
		stat              = '0;
		stat.is_append    = (op_q == OP_APPEND);
		stat.full         = full;
		stat.empty        = (count_q == '0);
		stat.total_zero   = (total_q == '0);
		stat.amt_ge_total = ({{(TOT_W-AMT_W){1'b0}}, amount_q} >= total_q);
		stat.mod_last     = (bit_q == '0);
		stat.walk_end     = rd_v_q & (hit | last);
	end

	always_comb begin
		if (cmd.append) begin
			idx_pick = count_q[IDX_W-1:0];
			sts_pick = STS_OK;
			cnt_pick = cnt_p1;
		end else begin
			cnt_pick = count_q;
			sts_pick = cmd.emit_status;
			case (cmd.emit_sel)
				SEL_LAST: idx_pick = cnt_m1[IDX_W-1:0];
				SEL_WALK: idx_pick = data_idx_q;
				default:  idx_pick = '0;
			endcase
		end
	end

	assign idx_ext = {{IDX_OUT_W{1'b0}}, idx_pick};
	assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_pick};

	// delay memory, registered read port
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem[count_q[IDX_W-1:0]] <= amount_q;
		end
		rdata_q <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			done_q  <= 1'b0;
			rd_v_q  <= 1'b0;
		end else begin
			done_q <= cmd.emit | cmd.append;
			if (cmd.append) begin
				count_q <= cnt_p1;
				total_q <= total_d;
			end
			if (cmd.walk_start) begin
				rd_v_q <= 1'b0;
			end else if (cmd.walk_step) begin
				rd_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= operation;
			amount_q <= amount_ms;
		end
		if (cmd.mod_start) begin
			rem_q <= '0;
			bit_q <= BIT_W'(AMT_W - 1);
		end else if (cmd.mod_step) begin
			rem_q <= rem_nxt[TOT_W-1:0];
			bit_q <= bit_q - BIT_W'(1);
		end else if (cmd.load_time) begin
			rem_q <= {{(TOT_W-AMT_W){1'b0}}, amount_q};
		end
		if (cmd.walk_start) begin
			rd_addr_q  <= '0;
			acc_q      <= '0;
			data_idx_q <= '0;
		end else if (cmd.walk_step) begin
			if (rd_addr_q != IDX_W'(MAX_FRAMES - 1)) begin
				rd_addr_q <= rd_addr_q + IDX_W'(1);
			end
			if (rd_v_q) begin
				acc_q      <= acc_sum;
				data_idx_q <= data_idx_q + IDX_W'(1);
			end
		end
		if (cmd.emit | cmd.append) begin
			frame_index_q <= idx_ext[IDX_OUT_W-1:0];
			status_q      <= sts_pick;
			frame_count_q <= cnt_ext[CNT_OUT_W-1:0];
			total_ms_q    <= cmd.append ? total_d : total_q;
		end
	end

	assign done        = done_q;
	assign frame_index = frame_index_q;
	assign status      = status_q;
	assign frame_count = frame_count_q;
	assign total_ms    = total_ms_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAMES))
		else $error("frame count past table depth");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> !full)
		else $error("append issued on full table");

	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk_step && rd_v_q) |-> (CNT_W'(data_idx_q) < count_q))
		else $error("walk evaluates entry past stored frames");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (status_q != 2'd3))
		else $error("undefined status code on result");

endmodule

[rtl/flt_ctrl.sv]
// controller state machine: accepts items, picks the path for append and lookup,
// sequences the modulo and the walk in flt_dp through command signals
// depends on flt_pkg
module flt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              loop_enable,
	input  flt_pkg::dp_stat_t stat,
	output flt_pkg::dp_cmd_t  cmd,
	output logic              busy
);
	import flt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DECIDE = 4'b0010,
		ST_MOD    = 4'b0100,
		ST_WALK   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_IDLE;
				if (stat.is_append) begin
					if (stat.full) begin
						cmd.emit        = 1'b1;
						cmd.emit_sel    = SEL_ZERO;
						cmd.emit_status = STS_FULL;
					end else begin
						cmd.append = 1'b1;
					end
				end else if (stat.empty || (loop_enable && stat.total_zero)) begin
					cmd.emit        = 1'b1;
					cmd.emit_sel    = SEL_ZERO;
					cmd.emit_status = STS_EMPTY;
				end else if (loop_enable) begin
					cmd.mod_start = 1'b1;
					state_d       = ST_MOD;
				end else if (stat.amt_ge_total) begin
					cmd.emit        = 1'b1;
					cmd.emit_sel    = SEL_LAST;
					cmd.emit_status = STS_OK;
				end else begin
					cmd.load_time  = 1'b1;
					cmd.walk_start = 1'b1;
					state_d        = ST_WALK;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					cmd.walk_start = 1'b1;
					state_d        = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.walk_end) begin
					cmd.emit        = 1'b1;
					cmd.emit_sel    = SEL_WALK;
					cmd.emit_status = STS_OK;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit && cmd.append))
		else $error("two result sources in one cycle");

	a_load_decides: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_DECIDE))
		else $error("accepted item not decided next cycle");

	a_mod_to_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD && stat.mod_last) |=> (state_q == ST_WALK && !stat.walk_end))
		else $error("modulo end did not start a fresh walk");

endmodule

[rtl/frame_timeline_lookup.sv]
// sequence: an append or trivial lookup is decided after accept and done is registered;
// a clamped walk reads one stored delay per cycle until it hits a frame or reaches the
// last stored one, and a looping lookup first runs the bit-serial modulo, then walks
// one item at a time, busy until the result is out
// reset clears frame count, total, loop_enable and the controller; the receiver cannot stall
// depends on flt_pkg, flt_ctrl, flt_dp
module frame_timeline_lookup #(
	parameter int MAX_FRAMES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [flt_pkg::AMT_W-1:0]     amount_ms,
	// result channel, one-cycle strobe
	output logic                          done,
	output logic [flt_pkg::IDX_OUT_W-1:0] frame_index,
	output logic [1:0]                    status,
	output logic [flt_pkg::CNT_OUT_W-1:0] frame_count,
	output logic [flt_pkg::TOT_W-1:0]     total_ms,
	// apb configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [flt_pkg::ADDR_W-1:0]    paddr,
	input  logic [flt_pkg::DATA_W-1:0]    pwdata,
	output logic [flt_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import flt_pkg::*;

	logic     loop_enable_q;
	logic     cfg_wr;
	logic     reg_hit;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// register index is the word address; unaligned low bits are ignored
	assign reg_hit = (paddr[2] == REG_LOOP_ENABLE);
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_enable_q <= 1'b0;
		end else if (cfg_wr && reg_hit) begin
			loop_enable_q <= pwdata[0];
		end
	end

	// read back, zero outside the register list
	assign prdata = reg_hit ? {{(DATA_W-1){1'b0}}, loop_enable_q} : '0;

	// controller: item transfer and path sequencing
	flt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.loop_enable (loop_enable_q),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy)
	);

	// datapath: delay memory, total, modulo, walk, result registers
	flt_dp #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.operation   (operation),
		.amount_ms   (amount_ms),
		.done        (done),
		.frame_index (frame_index),
		.status      (status),
		.frame_count (frame_count),
		.total_ms    (total_ms)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result transfer without an item in flight");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_hit) |=> (loop_enable_q == $past(pwdata[0])))
		else $error("loop_enable write lost");

endmodule
